// ----- src/wav_header_parse_sample_unpack_unit_defines.svh -----
// assertion macros used by the wav parser core
`ifndef WAV_HEADER_PARSE_SAMPLE_UNPACK_UNIT_DEFINES_SVH
`define WAV_HEADER_PARSE_SAMPLE_UNPACK_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define WAVHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WAVHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wavhp_pkg.sv -----
`default_nettype none

package wavhp_pkg;

    // fixed header layout
    localparam int unsigned HEADER_LEN       = 44;
    localparam int unsigned MAX_SAMPLE_BYTES = 4;

    localparam int unsigned POS_RIFF_SIZE = 4;
    localparam int unsigned POS_FMT_LO    = 20;
    localparam int unsigned POS_FMT_HI    = 21;
    localparam int unsigned POS_CHAN      = 22;
    localparam int unsigned POS_RATE      = 24;
    localparam int unsigned POS_BYTE_RATE = 28;
    localparam int unsigned POS_ALIGN     = 32;
    localparam int unsigned POS_BITS      = 34;
    localparam int unsigned POS_DATA_SIZE = 40;

    // "RIFF" as it arrives, first byte in the low lane
    localparam logic [31:0] RIFF_MAGIC = 32'h4646_4952;

    localparam int unsigned OUT_TDATA_W = 216;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NOT_RIFF  = 3'd1,
        ERR_NOT_PCM   = 3'd2,
        ERR_BAD_CHAN  = 3'd3,
        ERR_BAD_WIDTH = 3'd4
    } t_err;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        t_err        code;
        logic [31:0] riff_size;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] payload_size;
        logic [31:0] sample_value;
        logic        sample_channel;
    } t_result;

endpackage

`default_nettype wire

// ----- src/wavhp_core.sv -----
`default_nettype none
`include "wav_header_parse_sample_unpack_unit_defines.svh"

module wavhp_core
    import wavhp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic    [7:0] i_byte,
    input  wire logic    i_sof,
    output t_result      o_res
);

    t_phase      r_phase, n_phase, cur_phase;
    logic [5:0]  r_pos, n_pos, cur_pos;
    logic [23:0] r_shift, n_shift, cur_shift;
    logic [31:0] r_riff, n_riff, cur_riff;
    logic [15:0] r_chan, n_chan, cur_chan;
    logic [31:0] r_rate, n_rate, cur_rate;
    logic [31:0] r_brate, n_brate, cur_brate;
    logic [15:0] r_align, n_align, cur_align;
    logic [15:0] r_bits, n_bits, cur_bits;
    logic [31:0] r_left, n_left, cur_left;
    logic [1:0]  r_idx, n_idx, cur_idx;
    logic        r_tog, n_tog, cur_tog;

    t_err        err;
    logic [31:0] sample;
    logic [2:0]  idx_inc;
    logic [12:0] width;

    always_comb begin
        // start of file restarts everything with this byte as header byte 0
        if (i_sof) begin
            cur_phase = PH_HEADER;
            cur_pos   = '0;
            cur_shift = '0;
            cur_riff  = '0;
            cur_chan  = '0;
            cur_rate  = '0;
            cur_brate = '0;
            cur_align = '0;
            cur_bits  = '0;
            cur_left  = '0;
            cur_idx   = '0;
            cur_tog   = 1'b0;
        end else begin
            cur_phase = r_phase;
            cur_pos   = r_pos;
            cur_shift = r_shift;
            cur_riff  = r_riff;
            cur_chan  = r_chan;
            cur_rate  = r_rate;
            cur_brate = r_brate;
            cur_align = r_align;
            cur_bits  = r_bits;
            cur_left  = r_left;
            cur_idx   = r_idx;
            cur_tog   = r_tog;
        end

        n_phase = cur_phase;
        n_pos   = cur_pos;
        n_shift = cur_shift;
        n_riff  = cur_riff;
        n_chan  = cur_chan;
        n_rate  = cur_rate;
        n_brate = cur_brate;
        n_align = cur_align;
        n_bits  = cur_bits;
        n_left  = cur_left;
        n_idx   = cur_idx;
        n_tog   = cur_tog;

        err     = ERR_NONE;
        width   = '0;
        sample  = {8'h00, cur_shift} | (32'(i_byte) << {cur_idx, 3'b000});
        idx_inc = {1'b0, cur_idx} + 3'd1;
        o_res   = '0;

        case (cur_phase)
            PH_HEADER: begin
                n_pos = cur_pos + 6'd1;
                case (cur_pos) inside
                    [0:3]: begin
                        if (i_byte != RIFF_MAGIC[{cur_pos[1:0], 3'b000} +: 8]) begin
                            err = ERR_NOT_RIFF;
                        end
                    end
                    [POS_RIFF_SIZE:POS_RIFF_SIZE+3]: begin
                        n_riff[{cur_pos[1:0], 3'b000} +: 8] = i_byte;
                    end
                    POS_FMT_LO: begin
                        n_shift = {16'h0000, i_byte};
                    end
                    POS_FMT_HI: begin
                        if (cur_shift != 24'd1 || i_byte != 8'd0) begin
                            err = ERR_NOT_PCM;
                        end
                        n_shift = '0;
                    end
                    [POS_CHAN:POS_CHAN+1]: begin
                        n_chan[{cur_pos[0], 3'b000} +: 8] = i_byte;
                        if (cur_pos == 6'(POS_CHAN + 1) && n_chan != 16'd1
                                && n_chan != 16'd2) begin
                            err = ERR_BAD_CHAN;
                        end
                    end
                    [POS_RATE:POS_RATE+3]: begin
                        n_rate[{cur_pos[1:0], 3'b000} +: 8] = i_byte;
                    end
                    [POS_BYTE_RATE:POS_BYTE_RATE+3]: begin
                        n_brate[{cur_pos[1:0], 3'b000} +: 8] = i_byte;
                    end
                    [POS_ALIGN:POS_ALIGN+1]: begin
                        n_align[{cur_pos[0], 3'b000} +: 8] = i_byte;
                    end
                    [POS_BITS:POS_BITS+1]: begin
                        n_bits[{cur_pos[0], 3'b000} +: 8] = i_byte;
                        width = n_bits[15:3];
                        if (cur_pos == 6'(POS_BITS + 1) && (width == 13'd0
                                || width > 13'(MAX_SAMPLE_BYTES))) begin
                            err = ERR_BAD_WIDTH;
                        end
                    end
                    [POS_DATA_SIZE:POS_DATA_SIZE+3]: begin
                        n_left[{cur_pos[1:0], 3'b000} +: 8] = i_byte;
                    end
                    default: ;
                endcase

                if (err != ERR_NONE) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.code  = err;
                    n_phase     = PH_DONE;
                    n_pos       = cur_pos;
                end else if (cur_pos == 6'(HEADER_LEN - 1)) begin
                    o_res.valid         = 1'b1;
                    o_res.kind          = KIND_HEADER;
                    o_res.riff_size     = n_riff;
                    o_res.channel_count = n_chan;
                    o_res.sample_rate   = n_rate;
                    o_res.byte_rate     = n_brate;
                    o_res.block_align   = n_align;
                    o_res.sample_bits   = n_bits;
                    o_res.payload_size  = n_left;
                    n_shift             = '0;
                    n_idx               = '0;
                    n_tog               = 1'b0;
                    n_phase             = (n_left != 32'd0) ? PH_DATA : PH_DONE;
                end
            end
            PH_DATA: begin
                n_left = cur_left - 32'd1;
                // width was checked in range, so bits [5:3] hold it exactly
                if (idx_inc == cur_bits[5:3]) begin
                    o_res.valid          = 1'b1;
                    o_res.kind           = KIND_SAMPLE;
                    o_res.sample_value   = sample;
                    o_res.sample_channel = cur_tog;
                    n_shift              = '0;
                    n_idx                = '0;
                    if (cur_chan == 16'd2) begin
                        n_tog = ~cur_tog;
                    end
                end else begin
                    n_shift = sample[23:0];
                    n_idx   = idx_inc[1:0];
                end
                if (n_left == 32'd0) begin
                    n_phase = PH_DONE;
                end
            end
            default: ;
        endcase

        if (!i_step) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_idx   <= '0;
            r_tog   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_idx   <= n_idx;
            r_tog   <= n_tog;
        end
    end

    // captured header fields are cleared by start of file before first use
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_shift <= n_shift;
            r_riff  <= n_riff;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_brate <= n_brate;
            r_align <= n_align;
            r_bits  <= n_bits;
            r_left  <= n_left;
        end
    end

    `WAVHP_ASSERT_NOW(a_hdr_pos_range, i_clk, i_rst_n, r_phase == PH_HEADER, r_pos < 6'(HEADER_LEN), "header position past end")
    `WAVHP_ASSERT_NOW(a_idx_below_width, i_clk, i_rst_n, r_phase == PH_DATA, {1'b0, r_idx} < r_bits[5:3], "sample byte index not below width")
    `WAVHP_ASSERT_NEXT(a_error_stops, i_clk, i_rst_n, o_res.valid && o_res.kind == KIND_ERROR, r_phase == PH_DONE, "parser not stopped after error")
    `WAVHP_ASSERT_NEXT(a_payload_end, i_clk, i_rst_n, i_step && !i_sof && r_phase == PH_DATA && r_left == 32'd1, r_phase == PH_DONE, "parser not stopped at end of payload")

endmodule

`default_nettype wire

// ----- src/wav_header_parse_sample_unpack_unit.sv -----
`default_nettype none
// channel   | dir | handshake                     | contents
// ----------+-----+-------------------------------+---------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | file bytes, start of file in tuser
// m_axis    | out | m_axis_tvalid / m_axis_tready | header summary, sample or error
//
// one byte per cycle sustained while m_axis is ready; a result is offered on m_axis once its
// byte has passed the input register and the parse logic into the result register
// i_rst_n is synchronous and active low; after reset the parser ignores bytes until a
// start of file
// a stalled m_axis holds the result register; the input register then holds and
// s_axis_tready drops once both stages are full

module wav_header_parse_sample_unpack_unit
    import wavhp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]             s_axis_tuser,   // [0] start_of_file
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [2:0] error_code, [34:3] riff_size, [50:35] channel_count, [82:51] sample_rate,
    // [114:83] byte_rate, [130:115] block_align, [146:131] sample_bits,
    // [178:147] payload_size, [210:179] sample_value, [211] sample_channel,
    // [215:212] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                  m_axis_tuser    // [1:0] result_kind
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sof;

    // result register
    t_result    r_out;
    t_result    core_res;

    logic       advance;

    // the input item moves into the parser when the result slot is free or draining
    assign advance       = r_in_valid && (!r_out.valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_sof  <= s_axis_tuser[0];
        end
    end

    wavhp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_sof   (r_in_sof),
        .o_res   (core_res)
    );

    // a parse step with no result leaves the slot empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (advance) begin
            r_out <= core_res;
        end else if (m_axis_tready) begin
            r_out.valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out.valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {4'h0, r_out.sample_channel, r_out.sample_value,
                            r_out.payload_size, r_out.sample_bits, r_out.block_align,
                            r_out.byte_rate, r_out.sample_rate, r_out.channel_count,
                            r_out.riff_size, r_out.code};

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
    import wavhp_pkg::*;
();

    // run length and timing
    localparam int ITEM_TARGET  = 1050;     // input transactions before the stimulus stops
    localparam int QUIET_ITEMS  = 150;      // last stretch with no idling on either side
    localparam int DRAIN_CYCLES = 8;        // wait for the two-stage pipeline to empty, plus margin
    localparam int LONG_STALL   = 300;      // receiver hold-off, long enough to fill the block
    localparam int CYCLE_LIMIT  = 500000;

    // byte count of a file row: whole header plus whole payload
    localparam int FULL_FILE = -1;

    // content of header numbers and payload bytes in a file row
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // one result transaction, unpacked
    typedef struct packed {
        t_kind       kind;
        t_err        code;
        logic [31:0] riff_size;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] payload;
        logic [31:0] sval;
        logic        schan;
    } t_wav_result;

    // one file to be streamed in
    typedef struct packed {
        logic        lead_sof;      // first byte carries start of file
        logic [31:0] magic;
        logic [31:0] riff;
        logic [15:0] fmt;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] payload;
        int          n_bytes;       // FULL_FILE or an explicit count (truncation, trailing bytes)
        int          fill;
        t_err        exp_code;      // typed error for the row, ERR_NONE otherwise
    } t_file_case;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] data_byte
    logic [0:0]             s_axis_tuser;   // [0] start_of_file
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [2:0] error_code, [34:3] riff_size, [50:35] channel_count, [82:51] sample_rate,
    // [114:83] byte_rate, [130:115] block_align, [146:131] sample_bits,
    // [178:147] payload_size, [210:179] sample_value, [211] sample_channel, [215:212] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;   // [1:0] result_kind

    wav_header_parse_sample_unpack_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // parser model: own copy of the block state
    // ---------------------------------------------------------------
    t_phase      ph;
    logic [5:0]  hpos;
    logic [31:0] shift_acc;     // format low byte in the header, partial sample in data
    logic [31:0] riff_r;
    logic [15:0] chan_r;
    logic [31:0] rate_r;
    logic [31:0] brate_r;
    logic [15:0] align_r;
    logic [15:0] bits_r;
    logic [31:0] payload_r;     // data bytes still to come
    logic [2:0]  sidx;
    logic        tog;           // stereo left/right alternation

    task automatic clear_parser();
        ph        = PH_IDLE;
        hpos      = '0;
        shift_acc = '0;
        riff_r    = '0;
        chan_r    = '0;
        rate_r    = '0;
        brate_r   = '0;
        align_r   = '0;
        bits_r    = '0;
        payload_r = '0;
        sidx      = '0;
        tog       = 1'b0;
    endtask

    // advance the model by one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic sof, output logic emitted,
                              output t_wav_result r);
        t_err        err;
        int unsigned p;
        int unsigned w;
        logic [31:0] lane;
        emitted = 1'b0;
        r       = '0;
        err     = ERR_NONE;
        lane    = {24'd0, b};
        // a start clears everything, whatever the phase
        if (sof) begin
            clear_parser();
            ph = PH_HEADER;
        end
        if (ph == PH_HEADER) begin
            p = 32'(hpos);
            if (p < POS_RIFF_SIZE) begin
                if (b != RIFF_MAGIC[8*p +: 8]) err = ERR_NOT_RIFF;
            end else if (p < POS_RIFF_SIZE + 4) begin
                riff_r |= lane << (8 * (p - POS_RIFF_SIZE));
            end else if (p == POS_FMT_LO) begin
                shift_acc = lane;
            end else if (p == POS_FMT_HI) begin
                if (shift_acc != 32'd1 || b != 8'd0) err = ERR_NOT_PCM;
                shift_acc = '0;
            end else if (p == POS_CHAN || p == POS_CHAN + 1) begin
                chan_r |= {8'd0, b} << (8 * (p - POS_CHAN));
                if (p == POS_CHAN + 1 && chan_r != 16'd1 && chan_r != 16'd2)
                    err = ERR_BAD_CHAN;
            end else if (p >= POS_RATE && p < POS_RATE + 4) begin
                rate_r |= lane << (8 * (p - POS_RATE));
            end else if (p >= POS_BYTE_RATE && p < POS_BYTE_RATE + 4) begin
                brate_r |= lane << (8 * (p - POS_BYTE_RATE));
            end else if (p == POS_ALIGN || p == POS_ALIGN + 1) begin
                align_r |= {8'd0, b} << (8 * (p - POS_ALIGN));
            end else if (p == POS_BITS || p == POS_BITS + 1) begin
                bits_r |= {8'd0, b} << (8 * (p - POS_BITS));
                if (p == POS_BITS + 1) begin
                    w = bits_r / 8;
                    if (w == 0 || w > MAX_SAMPLE_BYTES) err = ERR_BAD_WIDTH;
                end
            end else if (p >= POS_DATA_SIZE && p < POS_DATA_SIZE + 4) begin
                payload_r |= lane << (8 * (p - POS_DATA_SIZE));
            end
            if (err != ERR_NONE) begin
                r.kind  = KIND_ERROR;
                r.code  = err;
                ph      = PH_DONE;
                emitted = 1'b1;
            end else begin
                hpos = hpos + 6'd1;
                if (hpos == HEADER_LEN) begin
                    r.kind      = KIND_HEADER;
                    r.riff_size = riff_r;
                    r.chans     = chan_r;
                    r.rate      = rate_r;
                    r.brate     = brate_r;
                    r.align     = align_r;
                    r.bits      = bits_r;
                    r.payload   = payload_r;
                    emitted     = 1'b1;
                    shift_acc   = '0;
                    sidx        = '0;
                    tog         = 1'b0;
                    // empty payload goes straight to done
                    ph = (payload_r != 0) ? PH_DATA : PH_DONE;
                end
            end
        end else if (ph == PH_DATA) begin
            w         = bits_r / 8;
            shift_acc |= lane << (8 * sidx);
            sidx      = sidx + 3'd1;
            payload_r = payload_r - 32'd1;
            if (sidx >= w) begin
                r.kind  = KIND_SAMPLE;
                r.sval  = shift_acc;
                r.schan = tog;
                if (chan_r == 16'd2) tog = ~tog;
                shift_acc = '0;
                sidx      = '0;
                emitted   = 1'b1;
            end
            // a trailing partial sample is dropped here
            if (payload_r == 0) ph = PH_DONE;
        end
    endtask

    // ---------------------------------------------------------------
    // expected results and checking
    // ---------------------------------------------------------------
    t_wav_result expected_results[$];
    int          fail_count = 0;
    int          sent_bytes = 0;
    t_err        typed_err;         // typed error of the directed row being sent

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (fail_count < 10)
                $display("mismatch in %s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_wav_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                if (fail_count < 10)
                    $display("result with nothing expected: kind %0d, tdata %h",
                             m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("error_code", 32'(want.code), 32'(m_axis_tdata[2:0]));
                check_field("riff_size", want.riff_size, m_axis_tdata[34:3]);
                check_field("channel_count", 32'(want.chans), 32'(m_axis_tdata[50:35]));
                check_field("sample_rate", want.rate, m_axis_tdata[82:51]);
                check_field("byte_rate", want.brate, m_axis_tdata[114:83]);
                check_field("block_align", 32'(want.align), 32'(m_axis_tdata[130:115]));
                check_field("sample_bits", 32'(want.bits), 32'(m_axis_tdata[146:131]));
                check_field("payload_size", want.payload, m_axis_tdata[178:147]);
                check_field("sample_value", want.sval, m_axis_tdata[210:179]);
                check_field("sample_channel", 32'(want.schan), 32'(m_axis_tdata[211]));
                check_field("tdata pad", 32'd0, 32'(m_axis_tdata[215:212]));
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog
    // ---------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random ready bursts, one long hold-off on request
    // ---------------------------------------------------------------
    logic rx_idle_on;
    logic stall_request;
    logic stall_taken = 1'b0;

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request && !stall_taken) begin
                // long hold-off while the sender keeps offering bytes
                stall_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------
    logic tx_idle_on;

    // offer one byte, wait for its transaction, then record what it should cause
    task automatic push_byte(input logic [7:0] b, input logic sof);
        logic        emitted;
        t_wav_result r;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_bytes++;
        parse_byte(b, sof, emitted, r);
        if (emitted) begin
            // error rows carry their result typed in
            if (typed_err != ERR_NONE) begin
                r      = '0;
                r.kind = KIND_ERROR;
                r.code = typed_err;
            end
            expected_results = {expected_results, r};
        end
    endtask

    function automatic logic [31:0] fill_word(input int fill);
        if (fill == FILL_ZERO) return 32'd0;
        if (fill == FILL_ONES) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // byte i of a file; unchecked header bytes are random
    function automatic logic [7:0] file_byte(input t_file_case c, input int i);
        logic [7:0] b;
        b = 8'($urandom);
        if (i < 4)                       b = c.magic[8*i +: 8];
        else if (i < 8)                  b = c.riff[8*(i-4) +: 8];
        else if (i >= 20 && i < 22)      b = c.fmt[8*(i-20) +: 8];
        else if (i >= 22 && i < 24)      b = c.chans[8*(i-22) +: 8];
        else if (i >= 24 && i < 28)      b = c.rate[8*(i-24) +: 8];
        else if (i >= 28 && i < 32)      b = c.brate[8*(i-28) +: 8];
        else if (i >= 32 && i < 34)      b = c.align[8*(i-32) +: 8];
        else if (i >= 34 && i < 36)      b = c.bits[8*(i-34) +: 8];
        else if (i >= 40 && i < 44)      b = c.payload[8*(i-40) +: 8];
        else if (i >= HEADER_LEN)        b = 8'(fill_word(c.fill));
        return b;
    endfunction

    function automatic t_file_case row(input logic lead, input logic [31:0] magic,
                                       input logic [15:0] fmt, input logic [15:0] chans,
                                       input logic [15:0] bits, input logic [31:0] payload,
                                       input int n_bytes, input int fill, input t_err code);
        t_file_case c;
        c.lead_sof = lead;
        c.magic    = magic;
        c.riff     = fill_word(fill);
        c.fmt      = fmt;
        c.chans    = chans;
        c.rate     = fill_word(fill);
        c.brate    = fill_word(fill);
        c.align    = 16'(fill_word(fill));
        c.bits     = bits;
        c.payload  = payload;
        c.n_bytes  = n_bytes;
        c.fill     = fill;
        c.exp_code = code;
        return c;
    endfunction

    task automatic send_file(input t_file_case c);
        int total;
        int i;
        total = (c.n_bytes == FULL_FILE) ? HEADER_LEN + int'(c.payload) : c.n_bytes;
        for (i = 0; i < total; i++)
            push_byte(file_byte(c, i), c.lead_sof && i == 0);
    endtask

    // mostly well-formed files with random content, the rest broken or noise
    function automatic t_file_case random_file();
        t_file_case c;
        int         roll;
        int         w;
        int         full;
        w = $urandom_range(1, MAX_SAMPLE_BYTES);
        c = row(1'b1, RIFF_MAGIC, 16'd1, 16'($urandom_range(1, 2)),
                16'(8 * w + $urandom_range(0, 7)),
                ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24),
                FULL_FILE, FILL_RANDOM, ERR_NONE);
        full = HEADER_LEN + int'(c.payload);
        roll = $urandom_range(0, 99);
        if (roll < 8)
            c.magic[8*$urandom_range(0, 3) +: 8] = 8'($urandom);
        else if (roll < 14)
            c.fmt = 16'($urandom);
        else if (roll < 20)
            c.chans = 16'($urandom);
        else if (roll < 26)
            c.bits = 16'($urandom);
        else if (roll < 34)
            c.n_bytes = int'($urandom_range(1, full - 1)); // next start lands mid-file
        else if (roll < 38) begin
            c.lead_sof = 1'b0;                             // stray bytes with no start
            c.n_bytes  = int'($urandom_range(1, 6));
        end else if (roll < 42)
            c.n_bytes = full + int'($urandom_range(1, 4)); // bytes past the payload
        return c;
    endfunction

    // let every expected result arrive, then wait DRAIN_CYCLES more
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    t_file_case cases[$];

    task automatic add_row(input t_file_case c);
        cases = {cases, c};
    endtask

    initial begin : stimulus
        t_file_case c;
        int         k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rx_idle_on    = 1'b1;
        tx_idle_on    = 1'b1;
        stall_request = 1'b0;
        typed_err     = ERR_NONE;
        clear_parser();

        // directed rows: lead, magic, format, channels, bits, payload, bytes, fill, error
        // bytes with no start after reset are ignored
        add_row(row(1'b0, RIFF_MAGIC, 16'd1, 16'd1, 16'd8, 4, 5, FILL_RANDOM, ERR_NONE));
        // magic wrong on the first byte, then on the last one
        add_row(row(1'b1, 32'h0, 16'd1, 16'd1, 16'd8, 4, 6, FILL_RANDOM, ERR_NOT_RIFF));
        add_row(row(1'b1, 32'hFF46_4952, 16'd1, 16'd1, 16'd8, 4, 6, FILL_RANDOM,
                    ERR_NOT_RIFF));
        // format not pcm
        add_row(row(1'b1, RIFF_MAGIC, 16'd0, 16'd1, 16'd8, 4, 24, FILL_RANDOM, ERR_NOT_PCM));
        add_row(row(1'b1, RIFF_MAGIC, 16'h0101, 16'd1, 16'd8, 4, 24, FILL_RANDOM,
                    ERR_NOT_PCM));
        add_row(row(1'b1, RIFF_MAGIC, 16'hFFFF, 16'd1, 16'd8, 4, 24, FILL_RANDOM,
                    ERR_NOT_PCM));
        // channel count out of range
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd0, 16'd8, 4, 26, FILL_RANDOM,
                    ERR_BAD_CHAN));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd3, 16'd8, 4, 26, FILL_RANDOM,
                    ERR_BAD_CHAN));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'hFFFF, 16'd8, 4, 26, FILL_RANDOM,
                    ERR_BAD_CHAN));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'h0201, 16'd8, 4, 26, FILL_RANDOM,
                    ERR_BAD_CHAN));
        // sample width zero or too wide
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd1, 16'd0, 4, 38, FILL_RANDOM,
                    ERR_BAD_WIDTH));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd1, 16'd7, 4, 38, FILL_RANDOM,
                    ERR_BAD_WIDTH));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd2, 16'd40, 4, 38, FILL_RANDOM,
                    ERR_BAD_WIDTH));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd2, 16'hFFFF, 4, 38, FILL_RANDOM,
                    ERR_BAD_WIDTH));
        // good files, sample widths of one to three bytes, mono and stereo, partial trailing sample
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd1, 16'd8, 6, FULL_FILE, FILL_ONES,
                    ERR_NONE));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd1, 16'd8, 4, FULL_FILE, FILL_ZERO,
                    ERR_NONE));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd2, 16'd16, 9, FULL_FILE, FILL_RANDOM,
                    ERR_NONE));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd2, 16'd24, 12, FULL_FILE, FILL_RANDOM,
                    ERR_NONE));
        // widest sample, all header numbers at their top
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd1, 16'd39, 8, FULL_FILE, FILL_ONES,
                    ERR_NONE));
        // empty payload, then bytes that must be ignored
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd2, 16'd16, 0, 47, FILL_RANDOM, ERR_NONE));
        // restart inside the header, then inside the data
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd2, 16'd16, 20, 30, FILL_RANDOM, ERR_NONE));
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd2, 16'd16, 20, 49, FILL_RANDOM, ERR_NONE));
        // stereo 8-bit, header numbers all zero
        add_row(row(1'b1, RIFF_MAGIC, 16'd1, 16'd2, 16'd8, 7, FULL_FILE, FILL_ZERO,
                    ERR_NONE));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < cases.size(); k++) begin
            typed_err = cases[k].exp_code;
            send_file(cases[k]);
        end
        typed_err = ERR_NONE;
        wait_drained();

        // receiver holds off while a long mono file streams in
        c = row(1'b1, RIFF_MAGIC, 16'd1, 16'd1, 16'd8, 40, FULL_FILE, FILL_RANDOM, ERR_NONE);
        stall_request = 1'b1;
        send_file(c);
        wait_drained();

        // random files; idling switched per file, none in the last stretch
        while (sent_bytes < ITEM_TARGET) begin
            tx_idle_on = (sent_bytes < ITEM_TARGET - QUIET_ITEMS) &&
                         ($urandom_range(0, 3) != 0);
            rx_idle_on = (sent_bytes < ITEM_TARGET - QUIET_ITEMS) &&
                         ($urandom_range(0, 3) != 0);
            send_file(random_file());
            if ($urandom_range(0, 29) == 0) wait_drained();
        end
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        wait_drained();

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- wav_header_parse_sample_unpack_unit.f -----
+incdir+src
src/wavhp_pkg.sv
src/wavhp_core.sv
src/wav_header_parse_sample_unpack_unit.sv
dv/tb_top.sv
